// ----- sv/tmco_pkg.sv -----
// ----------------------------------------------------------------------------
// tmco_pkg
// Shared widths, opcodes and types of the trimmed mean clock offset combiner.
// ----------------------------------------------------------------------------
package tmco_pkg;

	// field widths
	localparam int IDX_W  = 4;
	localparam int OFS_W  = 48;
	localparam int TIME_W = 48;
	localparam int USED_W = 5;

	// default number of source slots
	localparam int DEF_NUM_SOURCES = 16;

	// trimming and averaging constants
	localparam int TRIM_MIN  = 2;
	localparam int TRIM_DROP = 2;
	localparam int POW_CNT   = 8;
	localparam int POW_SHIFT = 3;

	// opcodes of an input word
	localparam logic OPC_REPORT = 1'b0;
	localparam logic OPC_RESYNC = 1'b1;

	// extreme offsets, start values of the max and min search
	localparam logic signed [OFS_W-1:0] OFS_MIN = {1'b1, {(OFS_W-1){1'b0}}};
	localparam logic signed [OFS_W-1:0] OFS_MAX = {1'b0, {(OFS_W-1){1'b1}}};

	// control from the sequencer to the slot walker
	typedef struct packed {
		logic wr_en;
		logic start;
	} walk_ctl_t;

endpackage

// ----- sv/tmco_walk.sv -----
// ----------------------------------------------------------------------------
// tmco_walk
// Offset store and slot walker: reads one slot a cycle and accumulates the
// sum, maximum, minimum and count of the slots that count.
// ----------------------------------------------------------------------------
module tmco_walk import tmco_pkg::*; #(
	parameter int NUM_SOURCES = DEF_NUM_SOURCES
) (
	input  logic                                                clk,
	input  logic                                                arst_n,
	input  walk_ctl_t                                           ctl,
	input  logic [((NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1)-1:0] wr_addr,
	input  logic signed [OFS_W-1:0]                             wr_data,
	input  logic [NUM_SOURCES-1:0]                              flags,
	output logic                                                done,
	output logic signed [OFS_W+$clog2(NUM_SOURCES+1)-1:0]       total,
	output logic signed [OFS_W-1:0]                             hi,
	output logic signed [OFS_W-1:0]                             lo,
	output logic [$clog2(NUM_SOURCES+1)-1:0]                    count
);

	localparam int ADDR_W = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;
	localparam int CNT_W  = $clog2(NUM_SOURCES + 1);
	localparam int SUM_W  = OFS_W + CNT_W;

	logic signed [OFS_W-1:0] mem_q [NUM_SOURCES];
	logic signed [OFS_W-1:0] rd_s1;
	logic                    vld_s1;
	logic                    last_s1;
	logic [CNT_W-1:0]        ptr_q;
	logic                    run_q;
	logic                    done_q;
	logic signed [SUM_W-1:0] total_q;
	logic signed [OFS_W-1:0] hi_q;
	logic signed [OFS_W-1:0] lo_q;
	logic [CNT_W-1:0]        count_q;

	// offset store, one write and one registered read port
	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_s1 <= mem_q[ptr_q[ADDR_W-1:0]];
	end

	// slot pointer and read stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q   <= 1'b0;
			ptr_q   <= '0;
			vld_s1  <= 1'b0;
			last_s1 <= 1'b0;
			done_q  <= 1'b0;
		end else if (ctl.start) begin
			run_q   <= 1'b1;
			ptr_q   <= '0;
			vld_s1  <= 1'b0;
			last_s1 <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= last_s1;
			if (run_q) begin
				vld_s1  <= flags[ptr_q[ADDR_W-1:0]];
				last_s1 <= (ptr_q == CNT_W'(NUM_SOURCES - 1));
				run_q   <= (ptr_q != CNT_W'(NUM_SOURCES - 1));
				ptr_q   <= ptr_q + 1'b1;
			end else begin
				vld_s1  <= 1'b0;
				last_s1 <= 1'b0;
			end
		end
	end

	// sum, max, min and count of counted slots
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			total_q <= '0;
			hi_q    <= OFS_MIN;
			lo_q    <= OFS_MAX;
			count_q <= '0;
		end else if (vld_s1) begin
			total_q <= total_q + SUM_W'(rd_s1);
			count_q <= count_q + 1'b1;
			if (rd_s1 > hi_q) begin
				hi_q <= rd_s1;
			end
			if (rd_s1 < lo_q) begin
				lo_q <= rd_s1;
			end
		end
	end

	assign done  = done_q;
	assign total = total_q;
	assign hi    = hi_q;
	assign lo    = lo_q;
	assign count = count_q;

endmodule

// ----- sv/tmco_div.sv -----
// ----------------------------------------------------------------------------
// tmco_div
// Bit-serial restoring divider: one quotient bit a cycle, unsigned operands.
// ----------------------------------------------------------------------------
module tmco_div import tmco_pkg::*; #(
	parameter int DVD_W = OFS_W + USED_W,
	parameter int DVS_W = USED_W
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic             done,
	output logic [DVD_W-1:0] quotient
);

	localparam int STEP_W = $clog2(DVD_W + 1);

	logic [DVD_W-1:0]  quo_q;
	logic [DVS_W-1:0]  rem_q;
	logic [DVS_W-1:0]  dvs_q;
	logic [STEP_W-1:0] step_q;
	logic              done_q;
	logic [DVS_W:0]    trial;
	logic              fits;
	logic [DVS_W:0]    diff;

	// trial subtract of the next dividend bit
	always_comb begin
		trial = {rem_q, quo_q[DVD_W-1]};
		fits  = (trial >= {1'b0, dvs_q});
		diff  = trial - {1'b0, dvs_q};
	end

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			step_q <= STEP_W'(DVD_W);
			done_q <= 1'b0;
		end else begin
			done_q <= (step_q == STEP_W'(1));
			if (step_q != '0) begin
				step_q <= step_q - 1'b1;
			end
		end
	end

	// dividend shifts out as quotient shifts in
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (step_q != '0) begin
			quo_q <= {quo_q[DVD_W-2:0], fits};
			rem_q <= fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ----- sv/trimmed_mean_clock_offset.sv -----
// ----------------------------------------------------------------------------
// trimmed_mean_clock_offset
// Combines offsets reported by time sources into a trimmed mean and returns
// the network time for every input word.
//
// channel | direction | handshake            | payload
// input   | in        | in_valid / in_stall  | opcode, source_index, source_ok,
//         |           |                      | source_offset, local_time_ms
// output  | out       | out_valid / out_stall| clock_offset, sync_done,
//         |           |                      | used_count, network_time_ms
//
// A report is handled one slot per cycle in the walker, then one quotient bit
// per cycle in the serial divider; the input stalls until its word is loaded
// into the output register. Resync and out-of-range reports skip the walk.
// Eight counted offsets skip the divider (shift).
// Reset is asynchronous and clears all slot marks, sync-done and the offset.
// A stalled output word holds; the next input word is taken while it waits.
// ----------------------------------------------------------------------------
module trimmed_mean_clock_offset import tmco_pkg::*; #(
	parameter int NUM_SOURCES = DEF_NUM_SOURCES
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic                     opcode,
	input  logic [IDX_W-1:0]         source_index,
	input  logic                     source_ok,
	input  logic signed [OFS_W-1:0]  source_offset,
	input  logic [TIME_W-1:0]        local_time_ms,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [OFS_W-1:0]  clock_offset,
	output logic                     sync_done,
	output logic [USED_W-1:0]        used_count,
	output logic [TIME_W-1:0]        network_time_ms
);

	localparam int ADDR_W = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;
	localparam int CNT_W  = $clog2(NUM_SOURCES + 1);
	localparam int SUM_W  = OFS_W + CNT_W;

	typedef enum logic [6:0] {
		S_IDLE    = 7'b0000001,
		S_WALK    = 7'b0000010,
		S_TRIM_HI = 7'b0000100,
		S_TRIM_LO = 7'b0001000,
		S_SEL     = 7'b0010000,
		S_DIV     = 7'b0100000,
		S_FIN     = 7'b1000000
	} tmco_state_t;

	tmco_state_t             state_q;
	logic [NUM_SOURCES-1:0]  rep_q;
	logic [NUM_SOURCES-1:0]  ok_q;
	logic                    synced_q;
	logic signed [OFS_W-1:0] comb_q;
	logic [TIME_W-1:0]       local_q;
	logic signed [SUM_W-1:0] total_q;
	logic [CNT_W-1:0]        cnt_q;
	logic                    neg_q;
	logic                    out_vld_q;
	logic signed [OFS_W-1:0] out_ofs_q;
	logic                    out_sync_q;
	logic [USED_W-1:0]       out_used_q;
	logic [TIME_W-1:0]       out_net_q;

	logic                    accept;
	logic                    in_range;
	logic [ADDR_W-1:0]       wr_addr;
	walk_ctl_t               walk_ctl;
	logic                    walk_done;
	logic signed [SUM_W-1:0] walk_total;
	logic signed [OFS_W-1:0] walk_hi;
	logic signed [OFS_W-1:0] walk_lo;
	logic [CNT_W-1:0]        walk_count;
	logic                    div_start;
	logic                    div_done;
	logic [SUM_W-1:0]        div_quo;
	logic [SUM_W-1:0]        tot_mag;
	logic [SUM_W-1:0]        quo_neg;
	logic signed [SUM_W-1:0] tot_asr;
	logic                    out_free;

	// input handshake and slot decode
	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && !in_stall;
	assign in_range = (32'(source_index) < NUM_SOURCES);
	assign wr_addr  = ADDR_W'(source_index);

	always_comb begin
		walk_ctl.wr_en = accept && (opcode == OPC_REPORT) && in_range;
		walk_ctl.start = walk_ctl.wr_en;
	end

	// operands for the final scaling
	assign tot_mag   = total_q[SUM_W-1] ? SUM_W'(-total_q) : SUM_W'(total_q);
	assign tot_asr   = total_q >>> POW_SHIFT;
	assign quo_neg   = -div_quo;
	assign div_start = (state_q == S_SEL) && (cnt_q != '0) && (32'(cnt_q) != POW_CNT);
	assign out_free  = !out_vld_q || !out_stall;

	tmco_walk #(
		.NUM_SOURCES(NUM_SOURCES)
	) u_walk (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (walk_ctl),
		.wr_addr(wr_addr),
		.wr_data(source_offset),
		.flags  (rep_q & ok_q),
		.done   (walk_done),
		.total  (walk_total),
		.hi     (walk_hi),
		.lo     (walk_lo),
		.count  (walk_count)
	);

	tmco_div #(
		.DVD_W(SUM_W),
		.DVS_W(CNT_W)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(tot_mag),
		.divisor (cnt_q),
		.done    (div_done),
		.quotient(div_quo)
	);

	// sequencer and combiner state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			rep_q    <= '0;
			ok_q     <= '0;
			synced_q <= 1'b0;
			comb_q   <= '0;
			cnt_q    <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (opcode == OPC_RESYNC) begin
							rep_q    <= '0;
							ok_q     <= '0;
							synced_q <= 1'b0;
							comb_q   <= '0;
							cnt_q    <= '0;
							state_q  <= S_FIN;
						end else if (in_range) begin
							rep_q[wr_addr] <= 1'b1;
							ok_q[wr_addr]  <= source_ok;
							synced_q       <= 1'b1;
							state_q        <= S_WALK;
						end else begin
							cnt_q   <= '0;
							state_q <= S_FIN;
						end
					end
				end
				S_WALK: begin
					if (walk_done) begin
						cnt_q   <= walk_count;
						state_q <= (32'(walk_count) > TRIM_MIN) ? S_TRIM_HI : S_SEL;
					end
				end
				S_TRIM_HI: begin
					cnt_q   <= cnt_q - CNT_W'(TRIM_DROP);
					state_q <= S_TRIM_LO;
				end
				S_TRIM_LO: begin
					state_q <= S_SEL;
				end
				S_SEL: begin
					if (cnt_q == '0) begin
						comb_q  <= '0;
						state_q <= S_FIN;
					end else if (32'(cnt_q) == POW_CNT) begin
						comb_q  <= tot_asr[OFS_W-1:0];
						state_q <= S_FIN;
					end else begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (div_done) begin
						comb_q  <= neg_q ? quo_neg[OFS_W-1:0] : div_quo[OFS_W-1:0];
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// running sum, trimmed in two steps
	always_ff @(posedge clk) begin
		if (accept) begin
			local_q <= local_time_ms;
		end
		if (state_q == S_WALK && walk_done) begin
			total_q <= walk_total;
		end else if (state_q == S_TRIM_HI) begin
			total_q <= total_q - SUM_W'(walk_hi);
		end else if (state_q == S_TRIM_LO) begin
			total_q <= total_q - SUM_W'(walk_lo);
		end
		if (div_start) begin
			neg_q <= total_q[SUM_W-1];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (state_q == S_FIN && out_free) begin
			out_vld_q <= 1'b1;
		end else if (!out_stall) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_FIN && out_free) begin
			out_ofs_q  <= comb_q;
			out_sync_q <= synced_q;
			out_used_q <= USED_W'(cnt_q);
			out_net_q  <= local_q + (synced_q ? TIME_W'(comb_q) : TIME_W'(0));
		end
	end

	assign out_valid       = out_vld_q;
	assign clock_offset    = out_ofs_q;
	assign sync_done       = out_sync_q;
	assign used_count      = out_used_q;
	assign network_time_ms = out_net_q;

	// a finished walk is only seen while the sequencer waits for it
	a_walk_done_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		walk_done |-> state_q == S_WALK)
		else $error("walk finished outside the walk state");

	// the divider never sees a zero divisor or the shift case
	a_div_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> (cnt_q != '0) && (32'(cnt_q) != POW_CNT))
		else $error("divider started with a bad divisor");

	// an unsynced word carries no offset and no count
	a_unsynced_word: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !sync_done |-> (clock_offset == '0) && (used_count == '0))
		else $error("unsynced word with an offset");

	// slot marks are cleared by a resync
	a_resync_clears: assert property (@(posedge clk) disable iff (!arst_n)
		accept && opcode == OPC_RESYNC |=> (rep_q == '0) && !synced_q)
		else $error("resync left slot marks");

	// the averaged count never exceeds the slot count
	a_used_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_FIN |-> 32'(cnt_q) <= NUM_SOURCES)
		else $error("averaged count out of range");

endmodule

// ----- tb/sv/tb_trimmed_mean_clock_offset.sv -----
// ----------------------------------------------------------------------------
// tb_trimmed_mean_clock_offset
// Self-checking bench for the trimmed mean clock offset combiner. A queue of
// words (directed corner cases, then random resync/report sequences) feeds a
// falling-edge driver. Every accepted word runs through a local predictor,
// and the rising-edge monitor compares each output word field by field.
// Both sides idle at random. The receiver also holds off once for a long
// stretch so that the block fills up and stalls its input.
// ----------------------------------------------------------------------------
module tb_trimmed_mean_clock_offset import tmco_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int NSRC         = DEF_NUM_SOURCES;
	localparam int NUM_WORDS    = 2000;
	localparam int IDLE_PCT     = 32;
	localparam int QUIET_LO     = 800;
	localparam int QUIET_HI     = 1100;
	localparam int HOLD_AT      = 400;
	localparam int HOLD_CYCLES  = 300;
	localparam int WDOG_LIMIT   = 5000;
	localparam int DRAIN_CYCLES = 200;

	typedef struct packed {
		logic                    opc;
		logic [IDX_W-1:0]        idx;
		logic                    ok;
		logic signed [OFS_W-1:0] ofs;
		logic [TIME_W-1:0]       lt;
	} offset_word_t;

	typedef struct packed {
		logic signed [OFS_W-1:0] offset;
		logic                    synced;
		logic [USED_W-1:0]       used;
		logic [TIME_W-1:0]       net;
	} offset_result_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    in_valid = 1'b0;
	logic                    in_stall;
	logic                    out_valid;
	logic                    out_stall = 1'b1;
	logic signed [OFS_W-1:0] clock_offset;
	logic                    sync_done;
	logic [USED_W-1:0]       used_count;
	logic [TIME_W-1:0]       network_time_ms;
	offset_word_t            cur_word = '0;

	// predictor state
	logic                    slot_reported [NSRC];
	logic                    slot_ok [NSRC];
	logic signed [OFS_W-1:0] slot_offset [NSRC];
	logic                    synced_q = 1'b0;
	logic signed [OFS_W-1:0] combined_q = '0;

	offset_word_t   pending_words [$];
	offset_result_t expected_results [$];
	logic signed [OFS_W-1:0] base_ofs = '0;
	int  sent_cnt = 0;
	int  got_cnt = 0;
	int  err_cnt = 0;
	int  quiet_cycles = 0;
	int  hold_left = 0;
	bit  hold_done = 0;
	bit  word_taken = 0;

	trimmed_mean_clock_offset u_top (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.opcode          (cur_word.opc),
		.source_index    (cur_word.idx),
		.source_ok       (cur_word.ok),
		.source_offset   (cur_word.ofs),
		.local_time_ms   (cur_word.lt),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.clock_offset    (clock_offset),
		.sync_done       (sync_done),
		.used_count      (used_count),
		.network_time_ms (network_time_ms)
	);

	// clock
	always #10 clk = ~clk;

	// expected result of one word, updates the slot state
	function automatic offset_result_t predict_combined(offset_word_t w);
		offset_result_t r;
		longint total;
		longint hi;
		longint lo;
		longint v;
		int n;
		n = 0;
		if (w.opc == OPC_RESYNC) begin
			for (int i = 0; i < NSRC; i++) begin
				slot_reported[i] = 1'b0;
				slot_ok[i] = 1'b0;
			end
			synced_q = 1'b0;
			combined_q = '0;
		end else begin
			slot_reported[w.idx] = 1'b1;
			slot_ok[w.idx] = w.ok;
			slot_offset[w.idx] = w.ofs;
			synced_q = 1'b1;
			total = 0;
			hi = longint'(OFS_MIN);
			lo = longint'(OFS_MAX);
			// walk every reported, successful slot
			for (int i = 0; i < NSRC; i++) begin
				if (slot_reported[i] && slot_ok[i]) begin
					v = longint'(slot_offset[i]);
					total += v;
					if (v > hi) hi = v;
					if (v < lo) lo = v;
					n++;
				end
			end
			// drop one largest and one smallest
			if (n > TRIM_MIN) begin
				total = total - hi - lo;
				n -= TRIM_DROP;
			end
			if (n == 0) combined_q = '0;
			else if (n == POW_CNT) combined_q = OFS_W'(total >>> POW_SHIFT);
			else combined_q = OFS_W'(total / longint'(n));
		end
		r.offset = combined_q;
		r.synced = synced_q;
		r.used = USED_W'(n);
		r.net = w.lt + (synced_q ? TIME_W'(combined_q) : '0);
		return r;
	endfunction

	task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] exp_val);
		$display("mismatch at output word %0d, %s: got %0h, expected %0h",
			got_cnt, field, got, exp_val);
		err_cnt++;
	endtask

	task automatic queue_word(logic opc, int idx, logic ok, logic signed [OFS_W-1:0] ofs,
		logic [TIME_W-1:0] lt);
		offset_word_t w;
		w.opc = opc;
		w.idx = IDX_W'(idx);
		w.ok = ok;
		w.ofs = ofs;
		w.lt = lt;
		pending_words.push_back(w);
	endtask

	function automatic logic signed [OFS_W-1:0] rand_offset();
		logic [63:0] raw;
		raw = {$urandom, $urandom};
		case ($urandom_range(0, 3))
			0: return OFS_W'($signed($urandom_range(0, 2000)) - 1000);
			1: return raw[OFS_W-1:0];
			2: return base_ofs + OFS_W'($signed($urandom_range(0, 200)) - 100);
			default: return $urandom_range(0, 1) ? OFS_MAX : OFS_MIN;
		endcase
	endfunction

	function automatic logic [TIME_W-1:0] rand_time();
		logic [63:0] raw;
		raw = {$urandom, $urandom};
		case ($urandom_range(0, 19))
			0: return '1;
			1: return '0;
			default: return raw[TIME_W-1:0];
		endcase
	endfunction

	// input driver, a held word stays until taken
	always @(negedge clk) begin
		if (arst_n && (!in_valid || word_taken)) begin
			word_taken = 0;
			if (pending_words.size() != 0 &&
				((sent_cnt >= QUIET_LO && sent_cnt < QUIET_HI) ||
				$urandom_range(0, 99) >= IDLE_PCT)) begin
				cur_word <= pending_words.pop_front();
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// output stall, with one long hold-off
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (!hold_done && got_cnt >= HOLD_AT) begin
			hold_done = 1;
			hold_left = HOLD_CYCLES - 1;
			out_stall <= 1'b1;
		end else if (got_cnt >= QUIET_LO && got_cnt < QUIET_HI) begin
			out_stall <= 1'b0;
		end else begin
			out_stall <= ($urandom_range(0, 99) < IDLE_PCT);
		end
	end

	// accept inputs, check outputs, watchdog
	always @(posedge clk) begin
		offset_result_t exp_r;
		if (arst_n) begin
			quiet_cycles++;
			if (in_valid && !in_stall) begin
				expected_results.push_back(predict_combined(cur_word));
				word_taken = 1;
				sent_cnt++;
				quiet_cycles = 0;
			end
			if (out_valid && !out_stall) begin
				quiet_cycles = 0;
				if (expected_results.size() == 0) begin
					report_mismatch("unexpected word", 64'(network_time_ms), 64'(0));
				end else begin
					exp_r = expected_results.pop_front();
					if (clock_offset !== exp_r.offset)
						report_mismatch("clock_offset", 64'(clock_offset), 64'(exp_r.offset));
					if (sync_done !== exp_r.synced)
						report_mismatch("sync_done", 64'(sync_done), 64'(exp_r.synced));
					if (used_count !== exp_r.used)
						report_mismatch("used_count", 64'(used_count), 64'(exp_r.used));
					if (network_time_ms !== exp_r.net)
						report_mismatch("network_time_ms", 64'(network_time_ms),
							64'(exp_r.net));
				end
				got_cnt++;
			end
			if (quiet_cycles >= WDOG_LIMIT) begin
				$display("timeout: no word moved for %0d cycles", WDOG_LIMIT);
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	// stimulus and end of run
	initial begin
		int k;
		for (int i = 0; i < NSRC; i++) begin
			slot_reported[i] = 1'b0;
			slot_ok[i] = 1'b0;
			slot_offset[i] = '0;
		end

		// directed: extremes, time wrap, failed source, duplicate extremes
		queue_word(OPC_RESYNC, 9, 1'b1, OFS_MAX, '0);
		queue_word(OPC_REPORT, 0, 1'b1, OFS_MAX, '1);
		queue_word(OPC_REPORT, 15, 1'b1, OFS_MIN, '0);
		queue_word(OPC_REPORT, 3, 1'b0, 48'sd12345, 48'd1000);
		queue_word(OPC_REPORT, 5, 1'b1, -48'sd7, '1);
		queue_word(OPC_REPORT, 6, 1'b1, OFS_MAX, 48'd77);
		queue_word(OPC_REPORT, 7, 1'b1, OFS_MIN, 48'd78);
		queue_word(OPC_RESYNC, 0, 1'b0, '0, '1);
		// ten good sources leave eight after trimming: shift path, negative sum
		for (int i = 0; i < 10; i++)
			queue_word(OPC_REPORT, i, 1'b1, OFS_W'(-(3 * i + 1)), 48'd5000 + i);
		queue_word(OPC_REPORT, 10, 1'b0, OFS_MAX, 48'd6000);
		// overwrite a good slot as failed, back to the divider
		queue_word(OPC_REPORT, 2, 1'b0, 48'sd99, 48'd6001);
		queue_word(OPC_REPORT, 11, 1'b1, 48'sd0, '0);
		queue_word(OPC_RESYNC, 15, 1'b1, OFS_MIN, '1);

		// random: mostly resync followed by a burst of reports, some noise
		while (pending_words.size() < NUM_WORDS) begin
			if ($urandom_range(0, 99) < 85) begin
				base_ofs = rand_offset();
				queue_word(OPC_RESYNC, $urandom_range(0, NSRC - 1), 1'($urandom_range(0, 1)),
					rand_offset(), rand_time());
				k = $urandom_range(1, 24);
				for (int j = 0; j < k; j++)
					queue_word(OPC_REPORT, $urandom_range(0, NSRC - 1),
						$urandom_range(0, 99) < 85, rand_offset(), rand_time());
			end else begin
				queue_word(1'($urandom_range(0, 1)), $urandom_range(0, NSRC - 1),
					1'($urandom_range(0, 1)), rand_offset(), rand_time());
			end
		end

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_words.size() != 0 || in_valid || expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (err_cnt == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
sv/tmco_pkg.sv
sv/tmco_walk.sv
sv/tmco_div.sv
sv/trimmed_mean_clock_offset.sv
tb/sv/tb_trimmed_mean_clock_offset.sv
